>>> hw/rtl/fbpd_pkg.sv
// Shared types, constants and the length table of the 4-bit CPU instruction predecoder.
package fbpd_pkg;

  localparam int ADDR_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;
  localparam int AVAIL_W = 2;
  localparam int LEN_W   = 2;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 4;

  typedef enum logic [3:0] {
    CLS_UNKNOWN    = 4'd0,
    CLS_ILLEGAL    = 4'd1,
    CLS_NOP        = 4'd2,
    CLS_CONDJUMP   = 4'd3,
    CLS_MOVE       = 4'd4,
    CLS_REGJUMP    = 4'd5,
    CLS_JUMP       = 4'd6,
    CLS_CALL       = 4'd7,
    CLS_ADD        = 4'd8,
    CLS_SUB        = 4'd9,
    CLS_EXCHANGE   = 4'd10,
    CLS_RETURN     = 4'd11,
    CLS_LOAD       = 4'd12,
    CLS_SHIFTLEFT  = 4'd13,
    CLS_SHIFTRIGHT = 4'd14
  } op_class_t;

  // Group 2 is marked with 3: its length comes from the opcode's low bit.
  localparam logic [LEN_W-1:0] LEN_BY_LOW_BIT = 2'd3;
  localparam logic [LEN_W-1:0] GROUP_LEN [16] = '{
    2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
  };

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  first_byte;
    logic [BYTE_W-1:0]  second_byte;
    logic [AVAIL_W-1:0] bytes_available;
  } insn_in_t;

  typedef struct packed {
    logic              decode_ok;
    op_class_t         op_class;
    logic [LEN_W-1:0]  insn_length;
    logic [ADDR_W-1:0] jump_target;
    logic              has_jump;
    logic [ADDR_W-1:0] fall_through;
    logic              has_fall_through;
    logic [BYTE_W-1:0] immediate;
    logic              has_immediate;
  } insn_out_t;

endpackage

>>> hw/rtl/fbpd_decode.sv
// Combinational predecode of one instruction: length, class and branch addresses.
module fbpd_decode
  import fbpd_pkg::*;
(
  input  insn_in_t  insn,
  output insn_out_t dec
);

  logic [NIB_W-1:0]  group;
  logic [NIB_W-1:0]  operand;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] page_target;
  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W-1:0] far_target;

  assign group       = insn.first_byte[BYTE_W-1:NIB_W];
  assign operand     = insn.first_byte[NIB_W-1:0];
  assign page_target = {insn.address[ADDR_W-1:BYTE_W], insn.second_byte};
  assign next_addr   = insn.address + ADDR_W'(len);
  assign far_target  = {operand, insn.second_byte};

  always_comb begin
    len = GROUP_LEN[group];
    if (len == LEN_BY_LOW_BIT) begin
      len = insn.first_byte[0] ? 2'd1 : 2'd2;
    end
  end

  always_comb begin
    dec                  = '0;
    dec.decode_ok        = 1'b1;
    dec.op_class         = CLS_UNKNOWN;
    dec.insn_length      = len;
    // A count of 3 acts as 2, and len never exceeds 2, so a plain compare works.
    if (len > insn.bytes_available) begin
      dec.decode_ok   = 1'b0;
      dec.op_class    = CLS_ILLEGAL;
      dec.insn_length = '0;
    end else begin
      case (group)
        4'd0: dec.op_class = (operand != '0) ? CLS_ILLEGAL : CLS_NOP;
        4'd1: begin
          dec.op_class         = CLS_CONDJUMP;
          dec.jump_target      = page_target;
          dec.has_jump         = 1'b1;
          dec.fall_through     = next_addr;
          dec.has_fall_through = 1'b1;
        end
        4'd2: begin
          if (len == 2'd2) begin
            dec.op_class      = CLS_MOVE;
            dec.immediate     = insn.second_byte;
            dec.has_immediate = 1'b1;
          end
        end
        4'd3: dec.op_class = operand[0] ? CLS_REGJUMP : CLS_MOVE;
        4'd4: begin
          dec.op_class    = CLS_JUMP;
          dec.jump_target = far_target;
          dec.has_jump    = 1'b1;
        end
        4'd5: begin
          dec.op_class         = CLS_CALL;
          dec.jump_target      = far_target;
          dec.has_jump         = 1'b1;
          dec.fall_through     = next_addr;
          dec.has_fall_through = 1'b1;
        end
        4'd6:  dec.op_class = CLS_ADD;
        // Increment-and-skip: taken path is the next instruction, loop back is page-relative.
        4'd7: begin
          dec.op_class         = CLS_CONDJUMP;
          dec.jump_target      = next_addr;
          dec.has_jump         = 1'b1;
          dec.fall_through     = page_target;
          dec.has_fall_through = 1'b1;
        end
        4'd8:  dec.op_class = CLS_ADD;
        4'd9:  dec.op_class = CLS_SUB;
        4'd10: dec.op_class = CLS_MOVE;
        4'd11: dec.op_class = CLS_EXCHANGE;
        4'd12: dec.op_class = CLS_RETURN;
        4'd13: dec.op_class = CLS_LOAD;
        4'd14: dec.op_class = CLS_UNKNOWN;
        default: begin
          case (operand)
            4'd5:    dec.op_class = CLS_SHIFTLEFT;
            4'd6:    dec.op_class = CLS_SHIFTRIGHT;
            4'd8:    dec.op_class = CLS_SUB;
            4'd14:   dec.op_class = CLS_ILLEGAL;
            4'd15:   dec.op_class = CLS_ILLEGAL;
            default: dec.op_class = CLS_UNKNOWN;
          endcase
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/four_bit_cpu_insn_predecode_core.sv
// Top level of the 4-bit CPU instruction predecoder: input register, decode, result register.
// Predecodes one instruction per cycle while the master side is ready. An accepted item is held in
// an input register, decoded by a single level of combinational logic and captured in a result
// register, from which it is presented on the master side; with the master side always ready the
// block takes a new item every cycle. Backpressure on the master side stalls both registers, and
// the slave side keeps taking items while either register has room. There is no state carried
// between items and no configuration.
module four_bit_cpu_insn_predecode_core
  import fbpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [11:0] address, [19:12] first_byte, [27:20] second_byte, [29:28] bytes_available
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [3:0] op_class, [5:4] insn_length, [17:6] jump_target, [29:18] fall_through,
  // [37:30] immediate
  output logic [M_DATA_W-1:0] m_tdata,
  // [0] decode_ok, [1] has_jump, [2] has_fall_through, [3] has_immediate
  output logic [M_USER_W-1:0] m_tuser
);

  insn_in_t  in_reg;
  logic      in_valid;
  insn_out_t dec;
  insn_out_t out_reg;
  logic      out_valid;
  logic      out_adv;
  logic      in_adv;

  assign out_adv  = !out_valid || m_tready;
  assign in_adv   = !in_valid || out_adv;
  assign s_tready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && s_tvalid) begin
      in_reg.address         <= s_tdata[11:0];
      in_reg.first_byte      <= s_tdata[19:12];
      in_reg.second_byte     <= s_tdata[27:20];
      in_reg.bytes_available <= s_tdata[29:28];
    end
  end

  fbpd_decode u_decode (
    .insn (in_reg),
    .dec  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result while the master side stalls.
  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      out_reg <= dec;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_reg.immediate, out_reg.fall_through, out_reg.jump_target,
                     out_reg.insn_length, out_reg.op_class};
  assign m_tuser  = {out_reg.has_immediate, out_reg.has_fall_through, out_reg.has_jump,
                     out_reg.decode_ok};

endmodule
